>>> rtl/matinv_pkg.sv
// shared constants for the 3x3 matrix inverse pipeline
`default_nettype none
package matinv_pkg;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int ENTRY_WIDTH_DEF = 32;
	// pipeline stages ahead of the divider: products, cofactors, det partials,
	// det products, det sum, magnitudes, numerators
	localparam int PRE_STAGES      = 7;
endpackage
`default_nettype wire

>>> rtl/matinv_in_if.sv
// input channel: one 3x3 matrix per beat
`default_nettype none
interface matinv_in_if #(
	parameter int ENTRY_WIDTH = matinv_pkg::ENTRY_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [ENTRY_WIDTH-1:0] m00, m01, m02;
	logic signed [ENTRY_WIDTH-1:0] m10, m11, m12;
	logic signed [ENTRY_WIDTH-1:0] m20, m21, m22;

	modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		input ready);
	modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		output ready);
endinterface
`default_nettype wire

>>> rtl/matinv_out_if.sv
// output channel: one inverse matrix and singular flag per beat
`default_nettype none
interface matinv_out_if #(
	parameter int ENTRY_WIDTH = matinv_pkg::ENTRY_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [ENTRY_WIDTH-1:0] r00, r01, r02;
	logic signed [ENTRY_WIDTH-1:0] r10, r11, r12;
	logic signed [ENTRY_WIDTH-1:0] r20, r21, r22;
	logic                          singular;

	modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
		singular, input ready);
	modport sink (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
		singular, output ready);
endinterface
`default_nettype wire

>>> rtl/matrix3_inverse_adjugate.sv
// Inverse of a 3x3 fixed-point matrix by adjugate and determinant.
// Channel mat carries one matrix per beat (nine signed entries with
// FRAC_BITS fraction bits); channel inv returns the inverse, rounded to
// nearest with ties away from zero and saturated, plus a singular flag.
// A zero determinant gives singular = 1 and all entries zero.
// Throughput: one matrix per cycle while inv.ready is high. The pipeline has
// seven front stages, then the restoring divider, which after an overflow
// stage retires one quotient bit per stage for all nine entries against the
// shared determinant, and then one output stage.
// Each stage holds while the stage after it is full and stalled, so
// bubbles are squeezed out and new beats are still taken while a result
// waits at the output register. When inv.ready is low the result holds.
// Reset clears all stage valid bits; data registers are not reset.
`default_nettype none
module matrix3_inverse_adjugate #(
	parameter int FRAC_BITS   = matinv_pkg::FRAC_BITS_DEF,
	parameter int ENTRY_WIDTH = matinv_pkg::ENTRY_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	matinv_in_if.sink     mat,
	matinv_out_if.source  inv
);
	localparam int W    = ENTRY_WIDTH;
	localparam int PW   = 2 * W;
	localparam int CW   = 2 * W + 1;
	localparam int DETW = 3 * W + 2;
	localparam int XW   = 4 * W + 2 * FRAC_BITS + 2;
	localparam int PRE  = matinv_pkg::PRE_STAGES;
	localparam int L    = PRE + W + 2;

	logic [L-1:0] v_q;
	logic [L:0]   en;

	always_comb begin
		en[L] = inv.ready;
		for (int k = L - 1; k >= 0; k--) begin
			en[k] = !v_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) v_q[0] <= mat.valid;
			for (int k = 1; k < L; k++) begin
				if (en[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	assign mat.ready = en[0];

	logic signed [W-1:0] a [3][3];
	assign a[0][0] = mat.m00;
	assign a[0][1] = mat.m01;
	assign a[0][2] = mat.m02;
	assign a[1][0] = mat.m10;
	assign a[1][1] = mat.m11;
	assign a[1][2] = mat.m12;
	assign a[2][0] = mat.m20;
	assign a[2][1] = mat.m21;
	assign a[2][2] = mat.m22;

	logic signed [PW-1:0]   pp_s1 [3][3];
	logic signed [PW-1:0]   ps_s1 [3][3];
	logic signed [W-1:0]    row_s1 [3];
	logic signed [W-1:0]    row_s2 [3];
	logic signed [CW-1:0]   cof_s2 [3][3];
	logic signed [CW-1:0]   cof_s3 [3][3];
	logic signed [CW-1:0]   cof_s4 [3][3];
	logic signed [CW-1:0]   cof_s5 [3][3];
	logic signed [CW:0]     plo_s3 [3];
	logic signed [CW:0]     phi_s3 [3];
	logic signed [DETW-1:0] dp_s4 [3];
	logic signed [DETW-1:0] det_s5;
	logic [CW-1:0]          aadj_s6 [3][3];
	logic [DETW-1:0]        adet_s6;
	logic                   neg_s6 [3][3];
	logic                   zero_s6;
	logic [XW-1:0]          num_s7 [3][3];
	logic [XW-1:0]          dsh_s7;
	logic                   neg_s7 [3][3];
	logic                   zero_s7;

	// cofactor products, adj[i][j] uses the transposed minor
	for (genvar i = 0; i < 3; i++) begin : g_prod
		for (genvar j = 0; j < 3; j++) begin : g_col
			localparam int I1 = (i + 1) % 3;
			localparam int I2 = (i + 2) % 3;
			localparam int J1 = (j + 1) % 3;
			localparam int J2 = (j + 2) % 3;
			always_ff @(posedge clk) begin
				if (en[0]) begin
					pp_s1[i][j] <= a[J1][I1] * a[J2][I2];
					ps_s1[i][j] <= a[J1][I2] * a[J2][I1];
				end
				if (en[1]) begin
					cof_s2[i][j] <= {pp_s1[i][j][PW-1], pp_s1[i][j]}
						- {ps_s1[i][j][PW-1], ps_s1[i][j]};
				end
				if (en[2]) cof_s3[i][j] <= cof_s2[i][j];
				if (en[3]) cof_s4[i][j] <= cof_s3[i][j];
				if (en[4]) cof_s5[i][j] <= cof_s4[i][j];
				if (en[5]) begin
					aadj_s6[i][j] <= cof_s5[i][j][CW-1] ? -cof_s5[i][j] : cof_s5[i][j];
					neg_s6[i][j]  <= cof_s5[i][j][CW-1] ^ det_s5[DETW-1];
				end
				if (en[6]) begin
					num_s7[i][j] <= (XW'(aadj_s6[i][j]) << (2 * FRAC_BITS + 1))
						+ XW'(adet_s6);
					neg_s7[i][j] <= neg_s6[i][j];
				end
			end
		end
	end

	// determinant split into partial products of the cofactor halves
	for (genvar j = 0; j < 3; j++) begin : g_det
		always_ff @(posedge clk) begin
			if (en[0]) row_s1[j] <= a[0][j];
			if (en[1]) row_s2[j] <= row_s1[j];
			if (en[2]) begin
				plo_s3[j] <= row_s2[j] * $signed({1'b0, cof_s2[j][0][W-1:0]});
				phi_s3[j] <= row_s2[j] * $signed(cof_s2[j][0][CW-1:W]);
			end
			if (en[3]) begin
				dp_s4[j] <= ({{(DETW-CW-1){phi_s3[j][CW]}}, phi_s3[j]} << W)
					+ {{(DETW-CW-1){plo_s3[j][CW]}}, plo_s3[j]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[4]) det_s5 <= dp_s4[0] + dp_s4[1] + dp_s4[2];
		if (en[5]) begin
			adet_s6 <= det_s5[DETW-1] ? -det_s5 : det_s5;
			zero_s6 <= (det_s5 == '0);
		end
		if (en[6]) begin
			// twice the divisor, aligned to the top quotient bit
			dsh_s7  <= XW'(adet_s6) << (W + 1);
			zero_s7 <= zero_s6;
		end
	end

	// restoring divider, one quotient bit per stage; first stage is overflow
	logic [XW-1:0] div_rem_s8 [W+1][3][3];
	logic [W-1:0]  div_quo_s8 [W+1][3][3];
	logic          div_ovf_s8 [W+1][3][3];
	logic          div_neg_s8 [W+1][3][3];
	logic [XW-1:0] div_dsh_s8 [W+1];
	logic          div_zero_s8 [W+1];

	for (genvar t = 0; t <= W; t++) begin : g_div
		logic [XW-1:0] dsh_in;
		logic          zero_in;
		if (t == 0) begin : g_first
			assign dsh_in  = dsh_s7;
			assign zero_in = zero_s7;
		end else begin : g_next
			assign dsh_in  = div_dsh_s8[t-1];
			assign zero_in = div_zero_s8[t-1];
		end

		always_ff @(posedge clk) begin
			if (en[PRE+t]) begin
				div_dsh_s8[t]  <= dsh_in >> 1;
				div_zero_s8[t] <= zero_in;
			end
		end

		for (genvar i = 0; i < 3; i++) begin : g_r
			for (genvar j = 0; j < 3; j++) begin : g_c
				logic [XW-1:0] rin;
				logic [W-1:0]  qin;
				logic          ovf_in;
				logic          neg_in;
				logic          ge;
				if (t == 0) begin : g_first
					assign rin    = num_s7[i][j];
					assign qin    = '0;
					assign ovf_in = 1'b0;
					assign neg_in = neg_s7[i][j];
				end else begin : g_next
					assign rin    = div_rem_s8[t-1][i][j];
					assign qin    = div_quo_s8[t-1][i][j];
					assign ovf_in = div_ovf_s8[t-1][i][j];
					assign neg_in = div_neg_s8[t-1][i][j];
				end
				assign ge = (rin >= dsh_in);

				always_ff @(posedge clk) begin
					if (en[PRE+t]) begin
						div_rem_s8[t][i][j] <= ge ? (rin - dsh_in) : rin;
						div_neg_s8[t][i][j] <= neg_in;
						if (t == 0) begin
							div_ovf_s8[t][i][j] <= ge;
							div_quo_s8[t][i][j] <= '0;
						end else begin
							div_ovf_s8[t][i][j] <= ovf_in;
							div_quo_s8[t][i][j] <= {qin[W-2:0], ge};
						end
					end
				end
			end
		end
	end

	// saturate, apply sign, force zero when singular
	logic signed [W-1:0] res_s9 [3][3];
	logic                sing_s9;

	for (genvar i = 0; i < 3; i++) begin : g_out
		for (genvar j = 0; j < 3; j++) begin : g_c
			logic [W-1:0] lim;
			logic [W-1:0] mag;
			assign lim = {1'b0, {(W-1){1'b1}}} + W'(div_neg_s8[W][i][j]);
			assign mag = (div_ovf_s8[W][i][j] || div_quo_s8[W][i][j] > lim)
				? lim : div_quo_s8[W][i][j];
			always_ff @(posedge clk) begin
				if (en[L-1]) begin
					if (div_zero_s8[W]) begin
						res_s9[i][j] <= '0;
					end else begin
						res_s9[i][j] <= div_neg_s8[W][i][j] ? -mag : mag;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[L-1]) sing_s9 <= div_zero_s8[W];
	end

	assign inv.valid    = v_q[L-1];
	assign inv.r00      = res_s9[0][0];
	assign inv.r01      = res_s9[0][1];
	assign inv.r02      = res_s9[0][2];
	assign inv.r10      = res_s9[1][0];
	assign inv.r11      = res_s9[1][1];
	assign inv.r12      = res_s9[1][2];
	assign inv.r20      = res_s9[2][0];
	assign inv.r21      = res_s9[2][1];
	assign inv.r22      = res_s9[2][2];
	assign inv.singular = sing_s9;
endmodule
`default_nettype wire
